// ===== rtl/core/keyed_slot_table_with_mask_query_macros.svh =====
// ----------------------------------------------------------------------------
// keyed slot table assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_WITH_MASK_QUERY_MACROS_SVH
`define KEYED_SLOT_TABLE_WITH_MASK_QUERY_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define KSTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define KSTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KSTQ_ASSERT(lbl, prop, msg)
`define KSTQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/kstq_pkg.sv =====
// ----------------------------------------------------------------------------
// kstq_pkg
// Shared widths, codes and controller/datapath structs of the slot table.
// ----------------------------------------------------------------------------
package kstq_pkg;

  localparam int KIND_W    = 3;
  localparam int KEY_W     = 32;
  localparam int SLOT_W    = 5;
  localparam int MASK_W    = 32;
  localparam int PAYLOAD_W = 64;
  localparam int STATUS_W  = 3;
  localparam int LIVE_W    = 6;

  localparam int DEF_MAX_ENTRIES  = 32;
  localparam int DEF_PAYLOAD_BITS = 64;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UNREGISTER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_NOKEY = 3'd3,
    STAT_RANGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RD_CUR    = 2'd0,
    RD_NEXT   = 2'd1,
    RD_ACCEPT = 2'd2,
    RD_LAST   = 2'd3
  } rd_sel_e;

  typedef enum logic [1:0] {
    OPC_SCAN   = 2'd0,
    OPC_FETCH  = 2'd1,
    OPC_DIRECT = 2'd2
  } opc_e;

  typedef struct packed {
    logic    cap;
    rd_sel_e rd_sel;
    logic    idx_inc;
    logic    hold_load;
    logic    out_mid;
    logic    fin;
    logic    move_wr;
  } cmd_t;

  typedef struct packed {
    opc_e in_opc;
    logic scan_end;
    logic hit;
    logic hold_vld;
    logic out_free;
    logic in_range;
    logic is_query;
    logic is_unreg;
  } stat_t;

endpackage

// ===== rtl/core/kstq_in_if.sv =====
// ----------------------------------------------------------------------------
// kstq_in_if
// Request channel of the slot table: one operation per beat.
// ----------------------------------------------------------------------------
interface kstq_in_if import kstq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [KEY_W-1:0]     light_key;
  logic [SLOT_W-1:0]    slot_index;
  logic [SLOT_W-1:0]    layer_bit;
  logic                 in_enabled;
  logic [MASK_W-1:0]    in_layer_mask;
  logic [PAYLOAD_W-1:0] in_payload;

  modport source (
    output valid, kind, light_key, slot_index, layer_bit, in_enabled,
           in_layer_mask, in_payload,
    input  ready
  );

  modport sink (
    input  valid, kind, light_key, slot_index, layer_bit, in_enabled,
           in_layer_mask, in_payload,
    output ready
  );
endinterface

// ===== rtl/core/kstq_out_if.sv =====
// ----------------------------------------------------------------------------
// kstq_out_if
// Result channel of the slot table: one result per beat.
// ----------------------------------------------------------------------------
interface kstq_out_if import kstq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 match_valid;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_enabled;
  logic [MASK_W-1:0]    out_layer_mask;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 last;
  logic [LIVE_W-1:0]    live_count;

  modport source (
    output valid, status, match_valid, out_slot, out_enabled, out_layer_mask,
           out_payload, last, live_count,
    input  ready
  );

  modport sink (
    input  valid, status, match_valid, out_slot, out_enabled, out_layer_mask,
           out_payload, last, live_count,
    output ready
  );
endinterface

// ===== rtl/core/kstq_ctrl.sv =====
// ----------------------------------------------------------------------------
// kstq_ctrl
// Sequencer: accepts an operation, walks the slots or fetches one by index,
// moves the tail slot on unregister, issues query matches and the final result.
// ----------------------------------------------------------------------------
module kstq_ctrl import kstq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_FETCH  = 5'b00100,
    S_MOVE   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.rd_sel = RD_CUR;
    in_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap    = 1'b1;
          cmd_o.rd_sel = RD_ACCEPT;
          unique case (stat_i.in_opc)
            OPC_SCAN:  state_d = S_SCAN;
            OPC_FETCH: state_d = S_FETCH;
            default:   state_d = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.scan_end) begin
          state_d = S_FINISH;
        end else if (stat_i.hit) begin
          if (stat_i.is_query) begin
            // a held match goes out only once the next one is known
            if (!stat_i.hold_vld) begin
              cmd_o.hold_load = 1'b1;
              cmd_o.idx_inc   = 1'b1;
              cmd_o.rd_sel    = RD_NEXT;
            end else if (stat_i.out_free) begin
              cmd_o.out_mid   = 1'b1;
              cmd_o.hold_load = 1'b1;
              cmd_o.idx_inc   = 1'b1;
              cmd_o.rd_sel    = RD_NEXT;
            end
          end else begin
            cmd_o.hold_load = 1'b1;
            if (stat_i.is_unreg) begin
              cmd_o.rd_sel = RD_LAST;
              state_d      = S_MOVE;
            end else begin
              state_d = S_FINISH;
            end
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
          cmd_o.rd_sel  = RD_NEXT;
        end
      end
      S_FETCH: begin
        cmd_o.hold_load = stat_i.in_range;
        state_d         = S_FINISH;
      end
      S_MOVE: begin
        cmd_o.move_wr = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/kstq_dp.sv =====
// ----------------------------------------------------------------------------
// kstq_dp
// Slot memory, operation registers, scan index, held entry, live count and
// the result register.
// ----------------------------------------------------------------------------
module kstq_dp import kstq_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  kstq_in_if.sink           in_i,
  kstq_out_if.source        out_o
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  // slot memory
  logic [KEY_W-1:0]        key_mem [MAX_ENTRIES];
  logic                    en_mem  [MAX_ENTRIES];
  logic [MASK_W-1:0]       mask_mem[MAX_ENTRIES];
  logic [PAYLOAD_BITS-1:0] pay_mem [MAX_ENTRIES];

  logic [KEY_W-1:0]        rd_key_q;
  logic                    rd_en_q;
  logic [MASK_W-1:0]       rd_mask_q;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;

  // captured operation
  logic [KIND_W-1:0]       kind_q;
  logic [KEY_W-1:0]        key_q;
  logic [SLOT_W-1:0]       sidx_q;
  logic [SLOT_W-1:0]       lbit_q;
  logic                    en_q;
  logic [MASK_W-1:0]       mask_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  logic [CW-1:0]           idx_q, idx_nxt;
  logic [CW-1:0]           count_q, count_d, count_m1;

  // held entry: key hit, fetched slot or pending query match
  logic                    hold_vld_q;
  logic [AW-1:0]           hold_slot_q;
  logic                    hold_en_q;
  logic [MASK_W-1:0]       hold_mask_q;
  logic [PAYLOAD_BITS-1:0] hold_pay_q;

  // result register
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic                    out_match_q;
  logic [SLOT_W-1:0]       out_slot_q;
  logic                    out_en_q;
  logic [MASK_W-1:0]       out_mask_q;
  logic [PAYLOAD_W-1:0]    out_pay_q;
  logic                    out_last_q;
  logic [LIVE_W-1:0]       out_live_q;

  logic                    is_reg, is_unreg, is_lookup, is_read, is_query;
  logic                    full, append_ok, has_entry, out_free, out_load;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic                    wr_en;
  status_e                 fin_status;
  opc_e                    in_opc;

  assign is_reg    = (kind_q == KIND_REGISTER);
  assign is_unreg  = (kind_q == KIND_UNREGISTER);
  assign is_lookup = (kind_q == KIND_LOOKUP);
  assign is_read   = (kind_q == KIND_READ);
  assign is_query  = (kind_q == KIND_QUERY);

  assign idx_nxt   = idx_q + 1'b1;
  assign count_m1  = count_q - 1'b1;
  assign full      = (count_q >= CW'(MAX_ENTRIES));
  assign append_ok = cmd_i.fin && is_reg && !hold_vld_q && !full;
  assign has_entry = hold_vld_q && (is_lookup || is_read || is_query);
  assign out_free  = !out_valid_q || out_o.ready;
  assign out_load  = cmd_i.out_mid || cmd_i.fin;

  always_comb begin
    unique case (in_i.kind) inside
      KIND_REGISTER, KIND_UNREGISTER, KIND_LOOKUP, KIND_QUERY: in_opc = OPC_SCAN;
      KIND_READ: in_opc = OPC_FETCH;
      default:   in_opc = OPC_DIRECT;
    endcase
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_ACCEPT: rd_addr = (in_i.kind == KIND_READ) ? in_i.slot_index[AW-1:0] : '0;
      RD_NEXT:   rd_addr = idx_nxt[AW-1:0];
      RD_LAST:   rd_addr = count_m1[AW-1:0];
      default:   rd_addr = idx_q[AW-1:0];
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (append_ok) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.fin && is_unreg && hold_vld_q) begin
      count_d = count_m1;
    end
  end

  always_comb begin
    case (kind_q) inside
      KIND_REGISTER: begin
        if (hold_vld_q) begin
          fin_status = STAT_DUP;
        end else if (full) begin
          fin_status = STAT_FULL;
        end else begin
          fin_status = STAT_OK;
        end
      end
      KIND_UNREGISTER, KIND_LOOKUP: fin_status = hold_vld_q ? STAT_OK : STAT_NOKEY;
      KIND_READ: fin_status = hold_vld_q ? STAT_OK : STAT_RANGE;
      default:   fin_status = STAT_OK;
    endcase
  end

  // move overwrites the hit slot with the tail, append fills the next free one
  assign wr_en   = cmd_i.move_wr || append_ok;
  assign wr_addr = cmd_i.move_wr ? hold_slot_q : count_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= cmd_i.move_wr ? rd_key_q  : key_q;
      en_mem[wr_addr]   <= cmd_i.move_wr ? rd_en_q   : en_q;
      mask_mem[wr_addr] <= cmd_i.move_wr ? rd_mask_q : mask_q;
      pay_mem[wr_addr]  <= cmd_i.move_wr ? rd_pay_q  : pay_q;
    end
    rd_key_q  <= key_mem[rd_addr];
    rd_en_q   <= en_mem[rd_addr];
    rd_mask_q <= mask_mem[rd_addr];
    rd_pay_q  <= pay_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q <= in_i.kind;
      key_q  <= in_i.light_key;
      sidx_q <= in_i.slot_index;
      lbit_q <= in_i.layer_bit;
      en_q   <= in_i.in_enabled;
      mask_q <= in_i.in_layer_mask;
      pay_q  <= in_i.in_payload[PAYLOAD_BITS-1:0];
    end
    if (cmd_i.hold_load) begin
      hold_slot_q <= is_read ? sidx_q[AW-1:0] : idx_q[AW-1:0];
      hold_en_q   <= rd_en_q;
      hold_mask_q <= rd_mask_q;
      hold_pay_q  <= rd_pay_q;
    end
    if (out_load) begin
      out_status_q <= cmd_i.fin ? fin_status : STAT_OK;
      out_last_q   <= cmd_i.fin;
      out_live_q   <= LIVE_W'(count_d);
      if (cmd_i.out_mid || has_entry) begin
        out_match_q <= 1'b1;
        out_slot_q  <= SLOT_W'(hold_slot_q);
        out_en_q    <= hold_en_q;
        out_mask_q  <= hold_mask_q;
        out_pay_q   <= PAYLOAD_W'(hold_pay_q);
      end else begin
        out_match_q <= 1'b0;
        out_slot_q  <= '0;
        out_en_q    <= 1'b0;
        out_mask_q  <= '0;
        out_pay_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      count_q     <= '0;
      hold_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cap) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_nxt;
      end
      count_q <= count_d;
      if (cmd_i.cap) begin
        hold_vld_q <= 1'b0;
      end else if (cmd_i.hold_load) begin
        hold_vld_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.in_opc   = in_opc;
    stat_o.scan_end = (idx_q >= count_q);
    stat_o.hit      = is_query ? (rd_en_q && rd_mask_q[lbit_q]) : (rd_key_q == key_q);
    stat_o.hold_vld = hold_vld_q;
    stat_o.out_free = out_free;
    stat_o.in_range = (LIVE_W'(sidx_q) < LIVE_W'(count_q));
    stat_o.is_query = is_query;
    stat_o.is_unreg = is_unreg;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.match_valid    = out_match_q;
  assign out_o.out_slot       = out_slot_q;
  assign out_o.out_enabled    = out_en_q;
  assign out_o.out_layer_mask = out_mask_q;
  assign out_o.out_payload    = out_pay_q;
  assign out_o.last           = out_last_q;
  assign out_o.live_count     = out_live_q;

endmodule

// ===== rtl/core/keyed_slot_table_with_mask_query.sv =====
// ----------------------------------------------------------------------------
// keyed_slot_table_with_mask_query
// Dense keyed table with append, swap-remove, lookup, indexed read and
// layer-mask query.
// ----------------------------------------------------------------------------
//  channel | modport    | beat
//  --------+------------+---------------------------------------------------
//  in_i    | sink       | one operation: kind, key, slot, layer bit, entry
//  out_o   | source     | one result; last marks the final one of an operation
//
//  one operation at a time. register, unregister, lookup: scan to a key hit or
//  the live count, move the tail slot on an unregister hit, then the final
//  result. read by index: fetch the slot. other kinds: result only. layer
//  query: scan all live slots, one per cycle until a match waits on a full
//  result register, which holds a query scan and the final beat until taken.
//  reset clears live count, index and valid flags; slots need no clearing.
// ----------------------------------------------------------------------------
`include "keyed_slot_table_with_mask_query_macros.svh"

module keyed_slot_table_with_mask_query import kstq_pkg::*; #(
  parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kstq_in_if.sink     in_i,
  kstq_out_if.source  out_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign in_i.ready = in_ready;

  kstq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kstq_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

  `KSTQ_ASSERT(a_live_bound, out_o.valid |-> (out_o.live_count <= LIVE_W'(MAX_ENTRIES)), "live count beyond capacity")
  `KSTQ_ASSERT(a_fin_free, cmd.fin |-> stat.out_free, "final result loaded over a pending beat")
  `KSTQ_ASSERT(a_fin_shown, cmd.fin |=> (out_o.valid && out_o.last), "final result not presented")
  `KSTQ_ASSERT(a_empty_last, (out_o.valid && !out_o.match_valid) |-> out_o.last, "entry-less result not last")
  `KSTQ_ASSERT_ALWAYS(a_mid_held, cmd.out_mid |-> (stat.hold_vld && stat.is_query), "query beat without held match")

endmodule
